/* design/mbf_pkg.sv */
package mbf_pkg;

  localparam int OFFSET_BITS_DEF       = 24;
  localparam int MAX_HEADING_LEVEL_DEF = 6;

  // window of seven stored bytes plus the incoming one
  localparam int WIN_LEN      = 8;
  localparam int LOOKAHEAD    = 7;
  localparam int DECIDE_DELAY = 6;

  localparam logic [7:0] CHAR_HASH     = 8'h23;
  localparam logic [7:0] CHAR_BACKTICK = 8'h60;
  localparam logic [7:0] CHAR_TILDE    = 8'h7E;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] CHAR_TAB      = 8'h09;
  localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;

  localparam logic [3:0] PRI_NONE    = 4'd0;
  localparam logic [3:0] PRI_FENCE   = 4'd7;
  localparam logic [3:0] PRI_PARA    = 4'd8;
  localparam logic [3:0] PRI_NEWLINE = 4'd9;

  localparam logic [1:0] HOLD_INIT = 2'd2;

  typedef enum logic [1:0] {
    KIND_HEADING = 2'd0,
    KIND_CODE    = 2'd1,
    KIND_PARA    = 2'd2,
    KIND_NEWLINE = 2'd3
  } kind_e;

  // results caused by one accepted byte
  typedef struct packed {
    logic            load;
    logic            text_end;
    logic [7:0]      mask;
    logic [7:0][3:0] pri;
  } run_t;

  // keep the lower nonzero priority
  function automatic logic [3:0] merge_pri(input logic [3:0] cur, input logic [3:0] pr);
    logic [3:0] res;
    res = cur;
    if (pr != PRI_NONE && (cur == PRI_NONE || pr < cur)) res = pr;
    return res;
  endfunction

  // heading level starting at w[s], zero if none
  function automatic logic [3:0] heading_at(input logic [7:0][7:0] w, input int s,
                                            input int max_lvl);
    int         lvl;
    logic       run;
    logic [3:0] res;
    lvl = 0;
    run = 1'b1;
    res = PRI_NONE;
    for (int j = 0; j < WIN_LEN; j++) begin
      if (j >= s && run) begin
        if (w[j] == CHAR_HASH) lvl++;
        else run = 1'b0;
      end
    end
    if (lvl != 0 && lvl <= max_lvl && (s + lvl) < WIN_LEN) begin
      if (w[3'(s + lvl)] == CHAR_SPACE || w[3'(s + lvl)] == CHAR_TAB) res = 4'(lvl);
    end
    return res;
  endfunction

endpackage

/* design/mbf_scan.sv */
module mbf_scan #(
  parameter int OFFSET_BITS       = mbf_pkg::OFFSET_BITS_DEF,
  parameter int MAX_HEADING_LEVEL = mbf_pkg::MAX_HEADING_LEVEL_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           text_byte_i,
  input  logic                 end_of_text_i,
  output mbf_pkg::run_t        run_o,
  output logic [OFFSET_BITS:0] base_o
);

  localparam int CW = OFFSET_BITS + 1;
  localparam logic [CW-1:0] COUNT_CAP = {1'b1, {(OFFSET_BITS-3){1'b0}}, 3'd7};

  logic [6:0][7:0] la_q;
  logic [6:0][3:0] pend_q;
  logic [6:0]      ls_q;
  logic [CW-1:0]   cnt_q;
  logic            inside_q, inside_d;
  logic            skip_q, skip_d;
  logic            blank_q, blank_d;
  logic [1:0]      hold_q, hold_d;

  logic [7:0][7:0] win;
  logic [7:0][3:0] pend;
  logic [7:0]      mask;
  logic            fence;

  assign win   = {text_byte_i, la_q};
  assign fence = (text_byte_i == mbf_pkg::CHAR_BACKTICK || text_byte_i == mbf_pkg::CHAR_TILDE)
                 && la_q[5] == text_byte_i && la_q[6] == text_byte_i;

  always_comb begin
    pend     = {mbf_pkg::PRI_NONE, pend_q};
    inside_d = inside_q;
    skip_d   = skip_q;
    hold_d   = hold_q;
    blank_d  = blank_q;

    // fence scan, two bytes behind the input
    if (!skip_q && hold_q == 2'd0) begin
      if (fence) begin
        if (!inside_q) begin
          pend[4]  = mbf_pkg::merge_pri(pend[4], mbf_pkg::PRI_FENCE);
          inside_d = 1'b1;
        end else begin
          inside_d = 1'b0;
        end
        skip_d = 1'b1;
      end
    end else if (hold_q != 2'd0) begin
      hold_d = hold_q - 2'd1;
    end
    if (skip_d && text_byte_i == mbf_pkg::CHAR_NEWLINE) begin
      skip_d = 1'b0;
      hold_d = mbf_pkg::HOLD_INIT;
      if (!inside_d) pend[7] = mbf_pkg::merge_pri(pend[7], mbf_pkg::PRI_FENCE);
    end

    // newline and blank line
    if (text_byte_i == mbf_pkg::CHAR_NEWLINE) begin
      pend[7] = mbf_pkg::merge_pri(pend[7],
                                   blank_q ? mbf_pkg::PRI_PARA : mbf_pkg::PRI_NEWLINE);
      blank_d = 1'b1;
    end else if (text_byte_i != mbf_pkg::CHAR_SPACE && text_byte_i != mbf_pkg::CHAR_TAB) begin
      blank_d = 1'b0;
    end

    if (ls_q[0]) pend[0] = mbf_pkg::merge_pri(pend[0],
                                              mbf_pkg::heading_at(win, 1, MAX_HEADING_LEVEL));
    // at end of text every line start in the window is decided now
    if (end_of_text_i) begin
      for (int k = 1; k < 7; k++) begin
        if (ls_q[k]) pend[k] = mbf_pkg::merge_pri(pend[k],
                                 mbf_pkg::heading_at(win, k + 1, MAX_HEADING_LEVEL));
      end
    end

    for (int k = 0; k < 8; k++) begin
      mask[k] = (pend[k] != mbf_pkg::PRI_NONE)
                && ((cnt_q + CW'(k)) >= CW'(mbf_pkg::DECIDE_DELAY))
                && (end_of_text_i || k == 0);
    end
  end

  assign run_o.load     = accept_i && (mask != 8'd0 || end_of_text_i);
  assign run_o.text_end = end_of_text_i;
  assign run_o.mask     = mask;
  assign run_o.pri      = pend;
  assign base_o         = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      la_q     <= '0;
      pend_q   <= '0;
      ls_q     <= 7'b1000000;
      cnt_q    <= '0;
      inside_q <= 1'b0;
      skip_q   <= 1'b0;
      blank_q  <= 1'b0;
      hold_q   <= mbf_pkg::HOLD_INIT;
    end else if (accept_i) begin
      if (end_of_text_i) begin
        la_q     <= '0;
        pend_q   <= '0;
        ls_q     <= 7'b1000000;
        cnt_q    <= '0;
        inside_q <= 1'b0;
        skip_q   <= 1'b0;
        blank_q  <= 1'b0;
        hold_q   <= mbf_pkg::HOLD_INIT;
      end else begin
        la_q     <= win[7:1];
        pend_q   <= pend[7:1];
        ls_q     <= {text_byte_i == mbf_pkg::CHAR_NEWLINE, ls_q[6:1]};
        cnt_q    <= (cnt_q < COUNT_CAP) ? cnt_q + CW'(1) : COUNT_CAP;
        inside_q <= inside_d;
        skip_q   <= skip_d;
        blank_q  <= blank_d;
        hold_q   <= hold_d;
      end
    end
  end

endmodule

/* design/mbf_out.sv */
module mbf_out #(
  parameter int OFFSET_BITS = mbf_pkg::OFFSET_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mbf_pkg::run_t          run_i,
  input  logic [OFFSET_BITS:0]   base_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   has_breakpoint_o,
  output logic [OFFSET_BITS-1:0] break_offset_o,
  output logic [3:0]             priority_res_o,
  output logic [1:0]             kind_o,
  output logic                   last_of_run_o,
  output logic                   text_done_o
);

  localparam int CW = OFFSET_BITS + 1;

  logic            valid_q;
  logic [7:0]      mask_q;
  logic [7:0][3:0] pri_q;
  logic [CW-1:0]   base_q;
  logic            end_q;

  logic [2:0]      idx;
  logic [7:0]      rest;
  logic            last;
  logic            bare;
  logic            take;
  logic [3:0]      pri_sel;
  logic [CW-1:0]   off_sum;
  mbf_pkg::kind_e  kind_sel;

  // lowest pending entry goes first
  always_comb begin
    idx = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (mask_q[k]) idx = 3'(k);
    end
  end

  assign rest    = mask_q & ~(8'b1 << idx);
  assign last    = (rest == 8'd0);
  assign bare    = end_q && (mask_q == 8'd0);
  assign take    = valid_q && out_ready_i;
  assign pri_sel = pri_q[idx];
  assign off_sum = base_q + CW'(idx) - CW'(mbf_pkg::DECIDE_DELAY);

  always_comb begin
    case (pri_sel)
      mbf_pkg::PRI_FENCE:   kind_sel = mbf_pkg::KIND_CODE;
      mbf_pkg::PRI_PARA:    kind_sel = mbf_pkg::KIND_PARA;
      mbf_pkg::PRI_NEWLINE: kind_sel = mbf_pkg::KIND_NEWLINE;
      default:              kind_sel = mbf_pkg::KIND_HEADING;
    endcase
  end

  assign in_ready_o       = !valid_q || (out_ready_i && last);
  assign out_valid_o      = valid_q;
  assign has_breakpoint_o = !bare;
  assign break_offset_o   = bare ? '0 : (off_sum[CW-1] ? '1 : off_sum[OFFSET_BITS-1:0]);
  assign priority_res_o   = bare ? mbf_pkg::PRI_NONE : pri_sel;
  assign kind_o           = bare ? mbf_pkg::KIND_HEADING : kind_sel;
  assign last_of_run_o    = last;
  assign text_done_o      = end_q && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (run_i.load) begin
      valid_q <= 1'b1;
    end else if (take && last) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_i.load) begin
      mask_q <= run_i.mask;
      pri_q  <= run_i.pri;
      base_q <= base_i;
      end_q  <= run_i.text_end;
    end else if (take && !last) begin
      mask_q <= rest;
    end
  end

  a_bare_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_breakpoint_o |-> text_done_o)
    else $error("bare marker outside end of text");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && text_done_o |-> last_of_run_o)
    else $error("text done on a result that is not last");

  a_break_has_pri: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_breakpoint_o |-> priority_res_o != mbf_pkg::PRI_NONE)
    else $error("breakpoint without priority");

  a_load_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_i.load |-> in_ready_o)
    else $error("result buffer loaded while busy");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && last && !run_i.load |=> !out_valid_o)
    else $error("result buffer not emptied after last transfer");

endmodule

/* design/markdown_breakpoint_finder_unit.sv */
// markdown breakpoint finder
//
// in channel: one text byte per transfer (text_byte_i, end_of_text_i on the
//   final byte of a text), in_valid_i / in_ready_o
// out channel: breakpoints in ascending offset order, at most one per offset,
//   with priority 1-6 heading, 7 code fence, 8 paragraph break, 9 newline
// latency: a byte's first result shows on the out channel the cycle after it;
//   an offset is decided six bytes after it arrives, or by the final byte
// throughput, with a ready receiver: one byte per cycle; a byte gives at
//   most one result except the final byte, which flushes up to eight results
//   (or one bare end marker) one per cycle, the in channel held off until the
//   last of them is taken; the result register takes a new byte in the same
//   cycle its last result leaves, so a stalled receiver stops the in channel
//   only while a result is waiting; nothing is dropped
// reset: window, count and fence flags clear, offset zero counts as a line
//   start; the same happens after every final byte, ready for the next text
module markdown_breakpoint_finder_unit #(
  parameter int OFFSET_BITS       = mbf_pkg::OFFSET_BITS_DEF,
  parameter int MAX_HEADING_LEVEL = mbf_pkg::MAX_HEADING_LEVEL_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             text_byte_i,
  input  logic                   end_of_text_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   has_breakpoint_o,
  output logic [OFFSET_BITS-1:0] break_offset_o,
  output logic [3:0]             priority_res_o,
  output logic [1:0]             kind_o,
  output logic                   last_of_run_o,
  output logic                   text_done_o
);

  mbf_pkg::run_t        run;
  logic [OFFSET_BITS:0] base;
  logic                 accept;

  // input transfer
  assign accept = in_valid_i && in_ready_o;

  // window state and the combinational decision logic
  mbf_scan #(
    .OFFSET_BITS      (OFFSET_BITS),
    .MAX_HEADING_LEVEL(MAX_HEADING_LEVEL)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .text_byte_i  (text_byte_i),
    .end_of_text_i(end_of_text_i),
    .run_o        (run),
    .base_o       (base)
  );

  // result register and flush sequencer
  mbf_out #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .run_i           (run),
    .base_i          (base),
    .in_ready_o      (in_ready_o),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .has_breakpoint_o(has_breakpoint_o),
    .break_offset_o  (break_offset_o),
    .priority_res_o  (priority_res_o),
    .kind_o          (kind_o),
    .last_of_run_o   (last_of_run_o),
    .text_done_o     (text_done_o)
  );

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int OFFSET_W    = mbf_pkg::OFFSET_BITS_DEF;
  localparam int MAX_LVL     = mbf_pkg::MAX_HEADING_LEVEL_DEF;
  localparam int RANDOM_ITEMS = 340;
  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD   = 90;
  localparam int TAIL_CYCLES = 16;
  localparam int PRINT_CAP   = 40;
  localparam longint unsigned OFFSET_MAX = (64'd1 << OFFSET_W) - 1;
  localparam longint unsigned COUNT_CAP  = OFFSET_MAX + 8;

  // one breakpoint as it leaves the out channel
  typedef struct packed {
    logic                has_bp;
    logic [OFFSET_W-1:0] offset;
    logic [3:0]          pri;
    mbf_pkg::kind_e      kind;
    logic                last;
    logic                done;
  } brk_t;

  // one row of the directed text
  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
    logic       typed;
    brk_t       want;
  } row_t;

  localparam brk_t NO_BRK   = '0;
  localparam brk_t BARE_END = '{has_bp: 1'b0, offset: '0, pri: mbf_pkg::PRI_NONE,
                                kind: mbf_pkg::KIND_HEADING, last: 1'b1, done: 1'b1};
  // a lone newline: the byte after it starts a line
  localparam brk_t NL_ALONE = '{has_bp: 1'b1, offset: 1, pri: mbf_pkg::PRI_NEWLINE,
                                kind: mbf_pkg::KIND_NEWLINE, last: 1'b1, done: 1'b1};

  localparam int N_ROWS = 25;
  localparam row_t DIR_ROWS [N_ROWS] = '{
    // single-byte texts: extremes and a lone newline
    '{8'h00, 1'b1, 1'b1, BARE_END},
    '{8'hFF, 1'b1, 1'b1, BARE_END},
    '{mbf_pkg::CHAR_NEWLINE, 1'b1, 1'b1, NL_ALONE},
    // two-byte text, too short to hold a fence
    '{mbf_pkg::CHAR_BACKTICK, 1'b0, 1'b0, NO_BRK},
    '{mbf_pkg::CHAR_BACKTICK, 1'b1, 1'b0, NO_BRK},
    // level six heading, paragraph break, fence open and close
    '{mbf_pkg::CHAR_HASH, 1'b0, 1'b0, NO_BRK},
    '{mbf_pkg::CHAR_HASH, 1'b0, 1'b0, NO_BRK},
    '{mbf_pkg::CHAR_HASH, 1'b0, 1'b0, NO_BRK},
    '{mbf_pkg::CHAR_HASH, 1'b0, 1'b0, NO_BRK},
    '{mbf_pkg::CHAR_HASH, 1'b0, 1'b0, NO_BRK},
    '{mbf_pkg::CHAR_HASH, 1'b0, 1'b0, NO_BRK},
    '{mbf_pkg::CHAR_TAB, 1'b0, 1'b0, NO_BRK},
    '{mbf_pkg::CHAR_NEWLINE, 1'b0, 1'b0, NO_BRK},
    '{mbf_pkg::CHAR_NEWLINE, 1'b0, 1'b0, NO_BRK},
    '{mbf_pkg::CHAR_BACKTICK, 1'b0, 1'b0, NO_BRK},
    '{mbf_pkg::CHAR_BACKTICK, 1'b0, 1'b0, NO_BRK},
    '{mbf_pkg::CHAR_BACKTICK, 1'b0, 1'b0, NO_BRK},
    '{mbf_pkg::CHAR_NEWLINE, 1'b0, 1'b0, NO_BRK},
    '{mbf_pkg::CHAR_BACKTICK, 1'b0, 1'b0, NO_BRK},
    '{mbf_pkg::CHAR_BACKTICK, 1'b0, 1'b0, NO_BRK},
    '{mbf_pkg::CHAR_BACKTICK, 1'b0, 1'b0, NO_BRK},
    '{mbf_pkg::CHAR_NEWLINE, 1'b1, 1'b0, NO_BRK},
    // fence line cut off by the end of text
    '{mbf_pkg::CHAR_TILDE, 1'b0, 1'b0, NO_BRK},
    '{mbf_pkg::CHAR_TILDE, 1'b0, 1'b0, NO_BRK},
    '{mbf_pkg::CHAR_TILDE, 1'b1, 1'b0, NO_BRK}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [7:0]          text_byte_i;
  logic                end_of_text_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                has_breakpoint_o;
  logic [OFFSET_W-1:0] break_offset_o;
  logic [3:0]          priority_res_o;
  logic [1:0]          kind_o;
  logic                last_of_run_o;
  logic                text_done_o;

  markdown_breakpoint_finder_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .text_byte_i      (text_byte_i),
    .end_of_text_i    (end_of_text_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .has_breakpoint_o (has_breakpoint_o),
    .break_offset_o   (break_offset_o),
    .priority_res_o   (priority_res_o),
    .kind_o           (kind_o),
    .last_of_run_o    (last_of_run_o),
    .text_done_o      (text_done_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // breakpoints still to come out, oldest first
  brk_t brk_q[$];
  int   err_count = 0;
  int   quiet_cycles = 0;
  bit   long_hold_req = 1'b0;
  int   burst_left = 0;
  logic [7:0] txt_q[$];

  // mirror of the finder state
  logic [7:0]      la_bytes[7];
  logic [3:0]      line_pri[8];
  logic            line_start[8];
  logic [7:0]      scan_win[8];
  longint unsigned seen_count;
  logic            in_code;
  logic            fence_skip;
  logic            blank_run;
  int              fence_hold;

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    if (err_count < PRINT_CAP)
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
    err_count++;
  endtask

  function automatic void clear_finder();
    for (int i = 0; i < 7; i++) la_bytes[i] = '0;
    for (int i = 0; i < 8; i++) begin
      line_pri[i]   = mbf_pkg::PRI_NONE;
      line_start[i] = 1'b0;
    end
    // offset zero counts as a line start
    line_start[6] = 1'b1;
    seen_count = 0;
    in_code    = 1'b0;
    fence_skip = 1'b0;
    blank_run  = 1'b0;
    fence_hold = int'(mbf_pkg::HOLD_INIT);
  endfunction

  function automatic void merge_at(int k, logic [3:0] pr);
    if (pr != mbf_pkg::PRI_NONE && (line_pri[k] == mbf_pkg::PRI_NONE || pr < line_pri[k]))
      line_pri[k] = pr;
  endfunction

  // '#' run from scan_win[s] closed by space or tab, level or none
  function automatic logic [3:0] heading_level(int s);
    int j;
    int lvl;
    j = s;
    lvl = 0;
    while (j < 8 && scan_win[j] == mbf_pkg::CHAR_HASH) begin
      lvl++;
      j++;
    end
    if (lvl == 0 || lvl > MAX_LVL || j >= 8) return mbf_pkg::PRI_NONE;
    return (scan_win[j] == mbf_pkg::CHAR_SPACE || scan_win[j] == mbf_pkg::CHAR_TAB) ?
           4'(lvl) : mbf_pkg::PRI_NONE;
  endfunction

  function automatic brk_t make_brk(logic has, longint unsigned off, logic [3:0] pr);
    brk_t r;
    r = '0;
    r.has_bp = has;
    r.offset = (off > OFFSET_MAX) ? OFFSET_MAX[OFFSET_W-1:0] : off[OFFSET_W-1:0];
    r.pri = pr;
    case (pr)
      mbf_pkg::PRI_FENCE:   r.kind = mbf_pkg::KIND_CODE;
      mbf_pkg::PRI_PARA:    r.kind = mbf_pkg::KIND_PARA;
      mbf_pkg::PRI_NEWLINE: r.kind = mbf_pkg::KIND_NEWLINE;
      default:              r.kind = mbf_pkg::KIND_HEADING;
    endcase
    return r;
  endfunction

  // advance the mirror by one byte; keep selects whether its breakpoints are queued
  task automatic predict_byte(input logic [7:0] b, input logic eot, input bit keep);
    longint unsigned p;
    brk_t found[$];
    p = seen_count;
    for (int i = 0; i < 7; i++) scan_win[i] = la_bytes[i];
    scan_win[7] = b;
    line_start[7] = (b == mbf_pkg::CHAR_NEWLINE);

    // fence scan, three equal characters ending at this byte
    if (!fence_skip && fence_hold == 0) begin
      if ((b == mbf_pkg::CHAR_BACKTICK || b == mbf_pkg::CHAR_TILDE)
          && scan_win[5] == b && scan_win[6] == b) begin
        if (!in_code) begin
          merge_at(4, mbf_pkg::PRI_FENCE);
          in_code = 1'b1;
        end else begin
          in_code = 1'b0;
        end
        fence_skip = 1'b1;
      end
    end else if (fence_hold > 0) begin
      fence_hold--;
    end
    // end of the fence line; a closing fence marks the next line
    if (fence_skip && b == mbf_pkg::CHAR_NEWLINE) begin
      fence_skip = 1'b0;
      fence_hold = int'(mbf_pkg::HOLD_INIT);
      if (!in_code) merge_at(7, mbf_pkg::PRI_FENCE);
    end

    if (b == mbf_pkg::CHAR_NEWLINE) begin
      merge_at(7, blank_run ? mbf_pkg::PRI_PARA : mbf_pkg::PRI_NEWLINE);
      blank_run = 1'b1;
    end else if (b != mbf_pkg::CHAR_SPACE && b != mbf_pkg::CHAR_TAB) begin
      blank_run = 1'b0;
    end

    if (line_start[0]) merge_at(0, heading_level(1));
    if (p >= mbf_pkg::DECIDE_DELAY && line_pri[0] != mbf_pkg::PRI_NONE)
      found.push_back(make_brk(1'b1, p - mbf_pkg::DECIDE_DELAY, line_pri[0]));

    if (eot) begin
      // flush the whole window
      for (int k = 1; k <= 6; k++)
        if (line_start[k]) merge_at(k, heading_level(k + 1));
      for (int k = 1; k < 8; k++)
        if (line_pri[k] != mbf_pkg::PRI_NONE && p + k >= mbf_pkg::DECIDE_DELAY)
          found.push_back(make_brk(1'b1, p + k - mbf_pkg::DECIDE_DELAY, line_pri[k]));
      if (found.size() == 0) found.push_back(make_brk(1'b0, 0, mbf_pkg::PRI_NONE));
      found[found.size()-1].last = 1'b1;
      found[found.size()-1].done = 1'b1;
      clear_finder();
    end else begin
      if (found.size() > 0) found[found.size()-1].last = 1'b1;
      for (int i = 0; i < 7; i++) begin
        la_bytes[i]   = scan_win[i+1];
        line_pri[i]   = line_pri[i+1];
        line_start[i] = line_start[i+1];
      end
      line_pri[7]   = mbf_pkg::PRI_NONE;
      line_start[7] = 1'b0;
      seen_count = (p < COUNT_CAP) ? p + 1 : COUNT_CAP;
    end

    if (keep) foreach (found[i]) brk_q.push_back(found[i]);
  endtask

  // offer one byte in bursts with random gaps, return after its transfer
  task automatic send_byte(input logic [7:0] b, input logic eot, input bit keep);
    int  gap;
    bit  took;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    text_byte_i   <= b;
    end_of_text_i <= eot;
    // ready is stable by the falling edge, the transfer happens at the next rising one
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
    predict_byte(b, eot, keep);
  endtask

  // hold the sender off until every expected breakpoint has left
  task automatic drain_pause();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (brk_q.size() != 0);
  endtask

  // one random text, mostly well-formed markdown, sometimes plain noise
  task automatic make_text();
    int n_tok;
    int n;
    logic [7:0] fc;
    txt_q.delete();
    case ($urandom_range(0, 7))
      0: begin
        n = $urandom_range(1, 10);
        repeat (n) txt_q.push_back(8'($urandom_range(0, 255)));
      end
      1: begin
        // very short text of fence characters only
        n = $urandom_range(1, 3);
        repeat (n)
          txt_q.push_back($urandom_range(0, 1) ? mbf_pkg::CHAR_BACKTICK : mbf_pkg::CHAR_TILDE);
      end
      default: begin
        n_tok = $urandom_range(1, 12);
        repeat (n_tok) begin
          case ($urandom_range(0, 7))
            0, 1: begin
              if ($urandom_range(0, 1)) txt_q.push_back(mbf_pkg::CHAR_NEWLINE);
              n = $urandom_range(1, 7);
              repeat (n) txt_q.push_back(mbf_pkg::CHAR_HASH);
              case ($urandom_range(0, 4))
                0:       txt_q.push_back(mbf_pkg::CHAR_TAB);
                1:       txt_q.push_back(8'($urandom_range(33, 126)));
                default: txt_q.push_back(mbf_pkg::CHAR_SPACE);
              endcase
              n = $urandom_range(1, 5);
              repeat (n) txt_q.push_back(8'($urandom_range(97, 122)));
            end
            2: begin
              fc = $urandom_range(0, 1) ? mbf_pkg::CHAR_BACKTICK : mbf_pkg::CHAR_TILDE;
              n = ($urandom_range(0, 5) == 0) ? 2 : $urandom_range(3, 4);
              repeat (n) txt_q.push_back(fc);
              if ($urandom_range(0, 5) == 0)
                txt_q.push_back(mbf_pkg::CHAR_BACKTICK ^ mbf_pkg::CHAR_TILDE ^ fc);
              n = $urandom_range(0, 4);
              repeat (n) txt_q.push_back(8'($urandom_range(97, 122)));
              if ($urandom_range(0, 4) != 0) txt_q.push_back(mbf_pkg::CHAR_NEWLINE);
            end
            3: txt_q.push_back(mbf_pkg::CHAR_NEWLINE);
            4: begin
              n = $urandom_range(0, 2);
              repeat (n)
                txt_q.push_back($urandom_range(0, 1) ? mbf_pkg::CHAR_SPACE : mbf_pkg::CHAR_TAB);
              txt_q.push_back(mbf_pkg::CHAR_NEWLINE);
            end
            5: begin
              n = $urandom_range(1, 8);
              repeat (n) txt_q.push_back(8'($urandom_range(97, 122)));
            end
            6: txt_q.push_back(8'($urandom_range(0, 255)));
            default: begin
              n = $urandom_range(1, 3);
              repeat (n) txt_q.push_back(mbf_pkg::CHAR_SPACE);
            end
          endcase
        end
      end
    endcase
  endtask

  // receiver: changing stall patterns plus one long hold-off on request
  initial begin : drain_side
    int mode;
    int mode_left;
    int hold_left;
    int tick;
    out_ready_i = 1'b0;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    tick = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= (tick % 4 == 0);
          default: out_ready_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // compare each breakpoint transfer with the oldest expectation
  always @(negedge clk_i) begin : result_check
    brk_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (brk_q.size() == 0) begin
        report_mismatch("unexpected result, offset", break_offset_o, 0);
      end else begin
        want = brk_q.pop_front();
        if (has_breakpoint_o !== want.has_bp)
          report_mismatch("has_breakpoint", has_breakpoint_o, want.has_bp);
        if (break_offset_o !== want.offset)
          report_mismatch("break_offset", break_offset_o, want.offset);
        if (priority_res_o !== want.pri)
          report_mismatch("priority_res", priority_res_o, want.pri);
        if (kind_o !== want.kind)
          report_mismatch("kind", kind_o, want.kind);
        if (last_of_run_o !== want.last)
          report_mismatch("last_of_run", last_of_run_o, want.last);
        if (text_done_o !== want.done)
          report_mismatch("text_done", text_done_o, want.done);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(negedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int  sent;
    bit  paused;
    in_valid_i    = 1'b0;
    text_byte_i   = '0;
    end_of_text_i = 1'b0;
    rst_ni        = 1'b0;
    clear_finder();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed text; typed rows still advance the mirror
    foreach (DIR_ROWS[i]) begin
      send_byte(DIR_ROWS[i].ch, DIR_ROWS[i].eot, !DIR_ROWS[i].typed);
      if (DIR_ROWS[i].typed) brk_q.push_back(DIR_ROWS[i].want);
    end
    drain_pause();

    // receiver goes quiet while the random texts keep coming
    long_hold_req = 1'b1;
    sent = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      make_text();
      foreach (txt_q[i]) send_byte(txt_q[i], i == txt_q.size() - 1, 1'b1);
      sent += txt_q.size();
      if (!paused && sent > RANDOM_ITEMS / 2) begin
        drain_pause();
        paused = 1'b1;
      end
    end

    in_valid_i <= 1'b0;
    while (brk_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
